[rtl/mpq_pkg.sv]
`timescale 1ns / 1ps

package mpq_pkg;

  localparam int unsigned MPQ_CAPACITY    = 1024;
  localparam int unsigned MPQ_DATA_WIDTH  = 32;
  localparam int unsigned MPQ_PORT_WIDTH  = 32;
  localparam int unsigned MPQ_COUNT_OUT_W = 11;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } mpq_status_e;

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } mpq_op_e;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;
    logic ext;
  } mpq_cmd_t;

  // Status a cell hands to its right-hand neighbor
  typedef struct packed {
    logic occ;  // cell holds an entry
    logic ge;   // held entry is at least the value being inserted
  } mpq_link_t;

endpackage

[rtl/max_priority_queue_unit.sv]
`timescale 1ns / 1ps
// Bounded max-priority queue built as a sorted chain of cells.
// Input channel (in_valid_i / in_ready_o) carries one beat per operation:
// op_i selects insert of value_in_i or extract of the largest entry.
// Output channel (out_valid_o / out_ready_i) returns one beat per operation:
// the extracted value (zero unless an extract succeeded), a status code
// (ok, extract on empty, insert dropped because full) and the entry count
// after the operation.
// Cell 0 always holds the maximum, so the result is formed in the accept
// cycle and registered: out_valid_o rises in the cycle after accept.
// Every operation updates all cells together (each cell compares the
// broadcast value with its own entry and may take its neighbor's entry),
// so one beat is taken per cycle as long as the output register drains.
// When the receiver stalls, the result register holds and in_ready_o drops
// until that beat is taken.
// Reset empties the chain and the output register; no clearing pass runs.

module max_priority_queue_unit
  import mpq_pkg::*;
#(
  parameter int unsigned CAPACITY   = MPQ_CAPACITY,
  parameter int unsigned DATA_WIDTH = MPQ_DATA_WIDTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       op_i,
  input  logic [MPQ_PORT_WIDTH-1:0]  value_in_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [MPQ_PORT_WIDTH-1:0]  value_out_o,
  output logic [1:0]                 status_o,
  output logic [MPQ_COUNT_OUT_W-1:0] count_out_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic                  in_fire;
  logic                  full, empty;
  logic [CntW-1:0]       count_q, count_d;
  logic [DATA_WIDTH-1:0] ins_data;
  logic [MPQ_PORT_WIDTH-1:0] head_ext;
  mpq_cmd_t              cmd;

  mpq_link_t             link   [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_q [CAPACITY];
  logic [CAPACITY-1:0]   occ_vec;

  logic                      out_valid_q, out_valid_d;
  logic [MPQ_PORT_WIDTH-1:0] value_q, value_d;
  mpq_status_e               status_q, status_d;
  logic [CntW-1:0]           cnt_out_q, cnt_out_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign full       = (count_q == CntW'(CAPACITY));
  assign empty      = (count_q == '0);

  generate
    if (DATA_WIDTH <= MPQ_PORT_WIDTH) begin : g_ins_cut
      assign ins_data = value_in_i[DATA_WIDTH-1:0];
    end else begin : g_ins_ext
      assign ins_data = {{(DATA_WIDTH - MPQ_PORT_WIDTH){value_in_i[MPQ_PORT_WIDTH-1]}},
                         value_in_i};
    end
    if (DATA_WIDTH >= MPQ_PORT_WIDTH) begin : g_out_cut
      assign head_ext = cell_q[0][MPQ_PORT_WIDTH-1:0];
    end else begin : g_out_ext
      assign head_ext = {{(MPQ_PORT_WIDTH - DATA_WIDTH){cell_q[0][DATA_WIDTH-1]}},
                         cell_q[0]};
    end
  endgenerate

  always_comb begin
    cmd.ins     = in_fire && (op_i == OP_INSERT) && !full;
    cmd.ext     = in_fire && (op_i == OP_EXTRACT) && !empty;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    value_d     = value_q;
    status_d    = status_q;
    cnt_out_d   = cnt_out_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_fire) begin
      out_valid_d = 1'b1;
      value_d     = '0;
      status_d    = ST_OK;
      if (op_i == OP_INSERT) begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end else begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          value_d = head_ext;
          count_d = count_q - CntW'(1);
        end
      end
      cnt_out_d = count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q   <= value_d;
    status_q  <= status_d;
    cnt_out_q <= cnt_out_d;
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      mpq_link_t             left;
      logic [DATA_WIDTH-1:0] left_data;
      logic                  right_occ;
      logic [DATA_WIDTH-1:0] right_data;

      if (gi == 0) begin : g_head
        // head takes the new value whenever its own entry is smaller
        assign left.occ  = 1'b1;
        assign left.ge   = 1'b1;
        assign left_data = ins_data;
      end else begin : g_mid
        assign left      = link[gi-1];
        assign left_data = cell_q[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_tail
        assign right_occ  = 1'b0;
        assign right_data = '0;
      end else begin : g_body
        assign right_occ  = link[gi+1].occ;
        assign right_data = cell_q[gi+1];
      end

      mpq_cell #(
        .DATA_WIDTH(DATA_WIDTH)
      ) u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .cmd_i       (cmd),
        .data_i      (ins_data),
        .left_i      (left),
        .left_data_i (left_data),
        .right_occ_i (right_occ),
        .right_data_i(right_data),
        .link_o      (link[gi]),
        .data_o      (cell_q[gi])
      );

      assign occ_vec[gi] = link[gi].occ;
    end

    if (CntW >= MPQ_COUNT_OUT_W) begin : g_cnt_cut
      assign count_out_o = cnt_out_q[MPQ_COUNT_OUT_W-1:0];
    end else begin : g_cnt_ext
      assign count_out_o = {{(MPQ_COUNT_OUT_W - CntW){1'b0}}, cnt_out_q};
    end
  endgenerate

  assign out_valid_o = out_valid_q;
  assign value_out_o = value_q;
  assign status_o    = status_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_occ_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(occ_vec) == int'(count_q))
    else $error("occupied cells disagree with entry count");

  a_head_is_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_vec[1] |-> ($signed(cell_q[0]) >= $signed(cell_q[1])))
    else $error("head cell is not the maximum");

  a_extract_drops_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ext |=> count_q == $past(count_q) - CntW'(1))
    else $error("extract did not lower the entry count");
`endif

endmodule

[rtl/mpq_cell.sv]
`timescale 1ns / 1ps

module mpq_cell
  import mpq_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = MPQ_DATA_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mpq_cmd_t              cmd_i,
  input  logic [DATA_WIDTH-1:0] data_i,
  input  mpq_link_t             left_i,
  input  logic [DATA_WIDTH-1:0] left_data_i,
  input  logic                  right_occ_i,
  input  logic [DATA_WIDTH-1:0] right_data_i,
  output mpq_link_t             link_o,
  output logic [DATA_WIDTH-1:0] data_o
);

  logic                  occ_q, occ_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic                  ge;

  assign ge = occ_q && ($signed(val_q) >= $signed(data_i));

  always_comb begin
    occ_d = occ_q;
    val_d = val_q;
    if (cmd_i.ins && !ge) begin
      // the new value lands in the first cell whose entry is smaller
      if (left_i.ge) begin
        occ_d = 1'b1;
        val_d = data_i;
      end else begin
        occ_d = left_i.occ;
        val_d = left_data_i;
      end
    end else if (cmd_i.ext) begin
      occ_d = right_occ_i;
      val_d = right_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign link_o.occ = occ_q;
  assign link_o.ge  = ge;
  assign data_o     = val_q;

endmodule
